// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the COBS frame decoder, included by its top level.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition on one edge implies another on the next edge.
`define CFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cfd_pkg.sv -----
// Package for the COBS frame decoder: result kinds, widths, frame limit.
// Used by cfd_core, cfd_result_reg and cobs_frame_decoder.
package cfd_pkg;

  localparam int MAX_FRAME = 256;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int BYTE_W    = 8;
  localparam int FLEN_W    = 9;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [FLEN_W-1:0]   frame_length;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]    count;
    logic                block_open;
    logic                zero_pending;
  } core_st_t;

endpackage

// ----- hw/rtl/cfd_core.sv -----
// Decoder state and the per-byte update: block counter, pending zero,
// decoded count and overflow flag. Depends on cfd_pkg.
module cfd_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [cfd_pkg::BYTE_W-1:0] byte_in,
  output logic                      has_res,
  output cfd_pkg::res_t             res,
  output cfd_pkg::core_st_t         st
);
  import cfd_pkg::*;

  logic [BYTE_W-1:0] rem_r, rem_nxt;
  logic              zp_r, zp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;

  logic              bad;
  logic              emit_try;
  logic [BYTE_W-1:0] emit_val;
  logic [BYTE_W-1:0] rem_base;
  logic              zp_mid;

  always_comb begin
    bad      = ovf_r || (rem_r != '0);
    has_res  = 1'b0;
    res      = '{kind: KIND_DATA, data_byte: '0, frame_length: '0};
    rem_nxt  = rem_r;
    zp_nxt   = zp_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    emit_try = 1'b0;
    emit_val = '0;
    rem_base = rem_r;
    zp_mid   = zp_r;
    if (byte_in == '0) begin
      has_res = 1'b1;
      res.kind = bad ? KIND_ERR : KIND_OK;
      res.frame_length = bad ? '0 : FLEN_W'(cnt_r);
      rem_nxt = '0;
      zp_nxt  = 1'b0;
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end else begin
      if (rem_r == '0) begin
        rem_base = byte_in;
        if (zp_r) begin
          zp_mid   = 1'b0;
          emit_try = 1'b1;
        end
      end else begin
        emit_try = 1'b1;
        emit_val = byte_in;
      end
      if (emit_try) begin
        if (cnt_r >= CNT_W'(MAX_FRAME)) begin
          ovf_nxt = 1'b1;
        end else begin
          cnt_nxt       = cnt_r + CNT_W'(1);
          has_res       = 1'b1;
          res.data_byte = emit_val;
        end
      end
      rem_nxt = rem_base - BYTE_W'(1);
      zp_nxt  = (rem_nxt == '0) ? 1'b1 : zp_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      zp_r  <= 1'b0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (step) begin
      rem_r <= rem_nxt;
      zp_r  <= zp_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign st = '{count: cnt_r, block_open: (rem_r != '0), zero_pending: zp_r};

endmodule

// ----- hw/rtl/cfd_result_reg.sv -----
// Result register in front of the out_ channel, valid/stall handshake.
// Depends on cfd_pkg for the result struct.
module cfd_result_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  cfd_pkg::res_t res_in,
  output logic          ready,
  output logic          out_valid,
  input  logic          out_stall,
  output cfd_pkg::res_t res_out
);
  import cfd_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// ----- hw/rtl/cobs_frame_decoder.sv -----
// Channel  | ports                                          | request
// in_      | in_valid, in_stall, in_byte                    | one received byte
// out_     | out_valid, out_stall, out_kind, out_data_byte, | one decoded byte
//          | out_frame_length, out_last_of_run              | or one frame end
// One byte per cycle sustained while out_stall is low; a byte with a result
// passes from the input register via cfd_core into the result register.
// Each byte yields zero or one result; out_last_of_run is always 1.
// Synchronous active-low reset clears the state and both valid flags.
// in_stall rises only when the input register holds a byte with a result
// and the result register is full and stalled.
// Top level of the COBS frame decoder; uses cfd_pkg, cfd_core, cfd_result_reg
// and assert_macros.svh.
`include "assert_macros.svh"

module cobs_frame_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cfd_pkg::BYTE_W-1:0] in_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_kind,
  output logic [cfd_pkg::BYTE_W-1:0] out_data_byte,
  output logic [cfd_pkg::FLEN_W-1:0] out_frame_length,
  output logic                       out_last_of_run
);
  import cfd_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_adv;
  logic              in_fire;
  logic              core_has_res;
  res_t              core_res;
  core_st_t          core_st;
  logic              res_ready;
  res_t              res_q;

  cfd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .byte_in (s1_byte_r),
    .has_res (core_has_res),
    .res     (core_res),
    .st      (core_st)
  );

  cfd_result_reg u_res (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_adv && core_has_res),
    .res_in    (core_res),
    .ready     (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_q)
  );

  assign s1_adv   = s1_valid_r && (!core_has_res || res_ready);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_byte;
    end
  end

  assign out_kind         = res_q.kind;
  assign out_data_byte    = res_q.data_byte;
  assign out_frame_length = res_q.frame_length;
  assign out_last_of_run  = 1'b1;

  `CFD_ASSERT(a_end_has_no_data, !out_valid || out_kind == KIND_DATA || out_data_byte == '0, "frame end carries a data byte")
  `CFD_ASSERT(a_data_has_no_len, !out_valid || out_kind != KIND_DATA || out_frame_length == '0, "data byte carries a frame length")
  `CFD_ASSERT(a_len_in_range, !out_valid || out_kind != KIND_OK || out_frame_length <= FLEN_W'(MAX_FRAME), "frame length beyond limit")
  `CFD_ASSERT_NEXT(a_delim_clears, s1_adv && s1_byte_r == '0, core_st.count == '0 && !core_st.block_open && !core_st.zero_pending, "state not cleared after delimiter")

endmodule
